// ===== rtl/bss_pkg.sv =====
// Package for the Bezier segment sample generator: widths, codes and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
package bss_pkg;

   localparam int MAX_SEG_LEN = 8192;
   localparam int LEN_W       = 14;
   localparam int LVL_W       = 16;
   localparam int POS_W       = 18;
   localparam int X_W         = 32;
   localparam int X_FRAC      = 16;
   localparam int T_FRAC      = 24;
   localparam int T_W         = 25;
   localparam int STEP_W      = 17;
   localparam int FILL_W      = 15;
   localparam int DIV_N_W     = 41;
   localparam int DIV_D_W     = 17;
   localparam int CNT_W       = 6;
   localparam int MUL_A_W     = 33;
   localparam int PROD_W      = 59;
   localparam int QUAL_W      = 4;
   localparam int IN_DATA_W   = 120;

   localparam logic [QUAL_W-1:0] QUAL_RESET = 4'd5;

   localparam logic [1:0] KIND_LINEAR = 2'd0;
   localparam logic [1:0] KIND_QUAD   = 2'd1;
   localparam logic [1:0] KIND_CUBIC  = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   typedef struct packed {
      logic       load;
      logic       out_empty;
      logic       out_sample;
      logic       lin_mul;
      logic       lin_div;
      logic       cand_init;
      logic       lerp_mul;
      logic       lerp_add;
      logic       lerp_y;
      logic [1:0] lerp_tail;
      logic       drop;
      logic       cand_upd;
   } bss_cmd_type;

   typedef struct packed {
      logic pending;
      logic linear;
      logic cubic;
      logic need_cand;
      logic steps_done;
      logic div_busy;
      logic out_free;
   } bss_status_type;

endpackage

// ===== rtl/bss_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on bss_pkg.
module bss_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bss_pkg::DIV_N_W-1:0]  dividend,
   input  logic [bss_pkg::DIV_D_W-1:0]  divisor,
   output logic                         busy,
   output logic [bss_pkg::DIV_N_W-1:0]  quotient,
   output logic [bss_pkg::DIV_D_W-1:0]  remainder
);

   logic [bss_pkg::DIV_N_W-1:0] q_ff, q_in;
   logic [bss_pkg::DIV_D_W-1:0] r_ff, r_in, d_ff, d_in;
   logic [bss_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic [bss_pkg::DIV_D_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff, q_ff[bss_pkg::DIV_N_W-1]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = bss_pkg::CNT_W'(bss_pkg::DIV_N_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = bss_pkg::DIV_D_W'(trial - {1'b0, d_ff});
            q_in = {q_ff[bss_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            r_in = trial[bss_pkg::DIV_D_W-1:0];
            q_in = {q_ff[bss_pkg::DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - bss_pkg::CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

// ===== rtl/bss_datapath.sv =====
// Datapath: segment registers, de Casteljau point registers, the shared
// interpolation multiplier, the serial divider and the result register.
// Depends on bss_pkg and bss_div.
module bss_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bss_pkg::QUAL_W-1:0]     csr_wdata,
   input  logic [bss_pkg::IN_DATA_W-1:0]  in_data,
   input  bss_pkg::bss_cmd_type           cmd,
   output bss_pkg::bss_status_type        status,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [bss_pkg::LVL_W-1:0]      rsp_level,
   output logic                           rsp_last,
   output logic                           rsp_empty
);

   localparam int LW = bss_pkg::LEN_W;
   localparam int VW = bss_pkg::LVL_W;
   localparam int XW = bss_pkg::X_W;
   localparam int AW = bss_pkg::MUL_A_W;
   localparam int PW = bss_pkg::PROD_W;
   localparam int T_W_L = bss_pkg::T_W;

   // Input word unpack.
   logic [1:0]                   in_kind;
   logic [LW-1:0]                in_len;
   logic signed [VW-1:0]         in_start, in_end, in_c1, in_c2;
   logic signed [bss_pkg::POS_W-1:0] in_pos1, in_pos2;
   logic [LW-1:0]                len_sat;

   assign in_kind  = in_data[1:0];
   assign in_len   = in_data[15:2];
   assign in_start = in_data[31:16];
   assign in_end   = in_data[47:32];
   assign in_c1    = in_data[63:48];
   assign in_c2    = in_data[79:64];
   assign in_pos1  = in_data[97:80];
   assign in_pos2  = in_data[115:98];
   assign len_sat  = (in_len > LW'(bss_pkg::MAX_SEG_LEN)) ?
                     LW'(bss_pkg::MAX_SEG_LEN) : in_len;

   logic [bss_pkg::QUAL_W-1:0]   quality_ff;
   logic [1:0]                   kind_ff;
   logic [LW-1:0]                len_ff, n_ff;
   logic signed [VW-1:0]         start_ff, end_ff, c1_ff, c2_ff, held_ff;
   logic signed [XW-1:0]         cx1_ff, cx2_ff;
   logic [bss_pkg::STEP_W-1:0]   step_ff;
   logic [bss_pkg::FILL_W-1:0]   fill_ff;
   logic                         pending_ff;
   logic signed [XW-1:0]         px_ff [4];
   logic signed [VW-1:0]         py_ff [4];
   logic signed [PW-1:0]         prod_ff;
   logic                         out_valid_ff;
   logic [VW-1:0]                out_level_ff;
   logic                         out_last_ff, out_empty_ff;

   logic [bss_pkg::QUAL_W-1:0]   qual_eff;
   logic [bss_pkg::STEP_W-1:0]   steps;
   logic [LW-1:0]                count;
   logic                         out_free;

   assign qual_eff = (quality_ff == '0) ? bss_pkg::QUAL_W'(1) : quality_ff;
   assign steps    = bss_pkg::STEP_W'(len_ff) * bss_pkg::STEP_W'(qual_eff);
   assign count    = (kind_ff == bss_pkg::KIND_LINEAR && len_ff == '0) ?
                     LW'(1) : len_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   // Shared multiplier: (b - a) * m, with a and b at the head of the point
   // registers, or the end levels and sample index for a linear segment.
   logic signed [AW-1:0]         mul_a, mul_b, lerp_sum;
   logic [T_W_L-1:0]             mul_m;
   logic [bss_pkg::DIV_N_W-1:0]  div_q;
   logic [bss_pkg::DIV_D_W-1:0]  div_r;
   logic                         div_busy, div_start;
   logic [bss_pkg::DIV_N_W-1:0]  div_n;
   logic [bss_pkg::DIV_D_W-1:0]  div_d;
   logic signed [PW-1:0]         prod_in, prod_mag;

   always_comb begin
      if (cmd.lin_mul) begin
         mul_a = AW'(start_ff);
         mul_b = AW'(end_ff);
         mul_m = T_W_L'(n_ff);
      end else if (cmd.lerp_y) begin
         mul_a = AW'(py_ff[0]);
         mul_b = AW'(py_ff[1]);
         mul_m = div_q[T_W_L-1:0];
      end else begin
         mul_a = AW'(px_ff[0]);
         mul_b = AW'(px_ff[1]);
         mul_m = div_q[T_W_L-1:0];
      end
   end

   assign prod_in  = PW'(mul_b - mul_a) * PW'($signed({1'b0, mul_m}));
   assign lerp_sum = mul_a + AW'(prod_ff >>> bss_pkg::T_FRAC);
   assign prod_mag = prod_ff[PW-1] ? -prod_ff : prod_ff;

   assign div_start = cmd.lin_div || cmd.cand_init;
   assign div_n = cmd.lin_div ? prod_mag[bss_pkg::DIV_N_W-1:0] :
                  {step_ff, {bss_pkg::T_FRAC{1'b0}}};
   assign div_d = cmd.lin_div ? bss_pkg::DIV_D_W'(count) : steps;

   bss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Floor division result for a linear segment.
   logic signed [AW-1:0]         lin_quo;
   logic [VW-1:0]                lin_level, sample_level;
   logic [LW-1:0]                n_next;
   logic                         cand_hit;

   always_comb begin
      if (!prod_ff[PW-1]) begin
         lin_quo = AW'(div_q);
      end else if (div_r != '0) begin
         lin_quo = -AW'(div_q) - AW'(1);
      end else begin
         lin_quo = -AW'(div_q);
      end
   end

   assign lin_level    = VW'(AW'(start_ff) + lin_quo);
   assign sample_level = (kind_ff == bss_pkg::KIND_LINEAR) ? lin_level : held_ff;
   assign n_next       = n_ff + LW'(1);
   // The finished candidate still sits in the second slot during the last drop.
   assign cand_hit     = px_ff[1] >= $signed({1'b0, fill_ff, {bss_pkg::X_FRAC{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff   <= bss_pkg::QUAL_RESET;
         kind_ff      <= bss_pkg::KIND_LINEAR;
         len_ff       <= '0;
         n_ff         <= '0;
         step_ff      <= '0;
         fill_ff      <= '0;
         held_ff      <= '0;
         pending_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            quality_ff <= csr_wdata;
         end
         if (cmd.load) begin
            kind_ff    <= (in_kind == bss_pkg::KIND_SPARE) ? bss_pkg::KIND_CUBIC : in_kind;
            len_ff     <= len_sat;
            n_ff       <= '0;
            step_ff    <= '0;
            fill_ff    <= '0;
            held_ff    <= in_start;
            pending_ff <= (in_kind == bss_pkg::KIND_LINEAR) || (len_sat != '0);
         end
         if (cmd.cand_upd) begin
            step_ff <= step_ff + bss_pkg::STEP_W'(1);
            if (cand_hit) begin
               held_ff <= py_ff[1];
               fill_ff <= px_ff[1][XW-2:bss_pkg::X_FRAC] + bss_pkg::FILL_W'(1);
            end
         end
         if (cmd.out_sample) begin
            n_ff <= n_next;
            if (n_next >= count) begin
               pending_ff <= 1'b0;
            end
         end
         if (cmd.out_sample || cmd.out_empty) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         start_ff <= in_start;
         end_ff   <= in_end;
         c1_ff    <= in_c1;
         c2_ff    <= in_c2;
         cx1_ff   <= XW'(in_pos1) * XW'($signed({1'b0, len_sat}));
         cx2_ff   <= XW'(in_pos2) * XW'($signed({1'b0, len_sat}));
      end
      if (cmd.lin_mul || cmd.lerp_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.cand_init) begin
         px_ff[0] <= '0;
         py_ff[0] <= start_ff;
         px_ff[1] <= cx1_ff;
         py_ff[1] <= c1_ff;
         if (kind_ff == bss_pkg::KIND_QUAD) begin
            px_ff[2] <= XW'({len_ff, {bss_pkg::X_FRAC{1'b0}}});
            py_ff[2] <= end_ff;
         end else begin
            px_ff[2] <= cx2_ff;
            py_ff[2] <= c2_ff;
            px_ff[3] <= XW'({len_ff, {bss_pkg::X_FRAC{1'b0}}});
            py_ff[3] <= end_ff;
         end
      end
      // Each interpolation pops the head and pushes its result at the tail
      // of the current level; a drop pops the leftover last point.
      if ((cmd.lerp_add && !cmd.lerp_y) || cmd.drop) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.lerp_add && cmd.lerp_tail == 2'(i)) begin
               px_ff[i] <= XW'(lerp_sum);
            end else begin
               px_ff[i] <= px_ff[i+1];
            end
         end
         if (cmd.lerp_add && cmd.lerp_tail == 2'd3) begin
            px_ff[3] <= XW'(lerp_sum);
         end
      end
      if ((cmd.lerp_add && cmd.lerp_y) || cmd.drop) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.lerp_add && cmd.lerp_tail == 2'(i)) begin
               py_ff[i] <= VW'(lerp_sum);
            end else begin
               py_ff[i] <= py_ff[i+1];
            end
         end
         if (cmd.lerp_add && cmd.lerp_tail == 2'd3) begin
            py_ff[3] <= VW'(lerp_sum);
         end
      end
      if (cmd.out_sample) begin
         out_level_ff <= sample_level;
         out_last_ff  <= (n_next == count);
         out_empty_ff <= 1'b0;
      end else if (cmd.out_empty) begin
         out_level_ff <= '0;
         out_last_ff  <= 1'b0;
         out_empty_ff <= 1'b1;
      end
   end

   assign status.pending    = pending_ff;
   assign status.linear     = (kind_ff == bss_pkg::KIND_LINEAR);
   assign status.cubic      = (kind_ff == bss_pkg::KIND_CUBIC);
   assign status.need_cand  = {1'b0, n_ff} >= fill_ff;
   assign status.steps_done = step_ff > steps;
   assign status.div_busy   = div_busy;
   assign status.out_free   = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_level  = out_level_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_empty  = out_empty_ff;

`ifndef SYNTHESIS
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sample || cmd.out_empty) |-> out_free)
      else $error("result written over an untaken word");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (n_ff < count))
      else $error("sample index past segment end while pending");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_busy)
      else $error("divider did not start");
`endif

endmodule

// ===== rtl/bss_ctrl.sv =====
// Controller state machine: sequences loads, linear division, candidate
// evaluation and result writes. Depends on bss_pkg.
module bss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_action,
   output logic                     req_tready,
   input  bss_pkg::bss_status_type  status,
   output bss_pkg::bss_cmd_type     cmd
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_REQ      = 11'b00000000010,
      S_LIN_MUL  = 11'b00000000100,
      S_LIN_DIV  = 11'b00000001000,
      S_LIN_WAIT = 11'b00000010000,
      S_CHECK    = 11'b00000100000,
      S_CAND_DIV = 11'b00001000000,
      S_LERP_MUL = 11'b00010000000,
      S_LERP_ADD = 11'b00100000000,
      S_DROP     = 11'b01000000000,
      S_OUT      = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] pts_ff, pts_in;    // points on the current level
   logic [1:0] op_ff, op_in;      // interpolations done on this level
   logic       y_ff, y_in;
   logic       empty_ff, empty_in;

   always_comb begin
      state_in   = state_ff;
      pts_in     = pts_ff;
      op_in      = op_ff;
      y_in       = y_ff;
      empty_in   = empty_ff;
      cmd        = '0;
      req_tready = (state_ff == S_IDLE);
      cmd.lerp_y    = y_ff;
      cmd.lerp_tail = 2'(pts_ff - 3'd1);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_action == bss_pkg::ACT_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  state_in = S_REQ;
               end
            end
         end
         S_REQ: begin
            empty_in = !status.pending;
            if (!status.pending) begin
               state_in = S_OUT;
            end else if (status.linear) begin
               state_in = S_LIN_MUL;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_LIN_MUL: begin
            cmd.lin_mul = 1'b1;
            state_in    = S_LIN_DIV;
         end
         S_LIN_DIV: begin
            cmd.lin_div = 1'b1;
            state_in    = S_LIN_WAIT;
         end
         S_LIN_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_CHECK: begin
            if (!status.need_cand || status.steps_done) begin
               state_in = S_OUT;
            end else begin
               cmd.cand_init = 1'b1;
               pts_in   = status.cubic ? 3'd4 : 3'd3;
               op_in    = '0;
               y_in     = 1'b0;
               state_in = S_CAND_DIV;
            end
         end
         S_CAND_DIV: begin
            if (!status.div_busy) begin
               state_in = S_LERP_MUL;
            end
         end
         S_LERP_MUL: begin
            cmd.lerp_mul = 1'b1;
            state_in     = S_LERP_ADD;
         end
         S_LERP_ADD: begin
            cmd.lerp_add = 1'b1;
            y_in         = !y_ff;
            state_in     = S_LERP_MUL;
            if (y_ff) begin
               op_in = op_ff + 2'd1;
               if (3'(op_ff + 2'd1) == 3'(pts_ff - 3'd1)) begin
                  state_in = S_DROP;
               end
            end
         end
         S_DROP: begin
            cmd.drop = 1'b1;
            pts_in   = pts_ff - 3'd1;
            op_in    = '0;
            if (pts_ff == 3'd2) begin
               cmd.cand_upd = 1'b0;
               state_in     = S_CHECK;
            end else begin
               state_in = S_LERP_MUL;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_sample = !empty_ff;
               cmd.out_empty  = empty_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // The candidate is complete once the final level has one point left.
      if (state_ff == S_DROP && pts_ff == 3'd2) begin
         cmd.cand_upd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pts_ff   <= '0;
         op_ff    <= '0;
         y_ff     <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pts_ff   <= pts_in;
         op_ff    <= op_in;
         y_ff     <= y_in;
         empty_ff <= empty_in;
      end
   end

endmodule

// ===== rtl/bezier_segment_sample_generator.sv =====
// Top level of the Bezier segment sample generator.
// Depends on bss_pkg, bss_ctrl and bss_datapath.
//
//   port group  dir  tdata / tuser / tlast
//   req_        in   segment fields / action / -
//   rsp_        out  sample_level / segment_empty / last_sample
//   csr_        in   curve_quality, write only
//
// A load word is taken while idle, and the controller stays ready for the next
// word. A linear sample runs a multiply and then a division in the 41-step
// serial divider. A curve sample evaluates roughly curve_quality candidates per
// sample, each with its own division and its own de Casteljau interpolations.
// A new word is taken only when the previous one is finished; a finished word
// waits in the result register while the next is taken, and a sample stalls
// only while that register still holds an untaken word.
// Reset is synchronous and clears all control state.
module bezier_segment_sample_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bss_pkg::QUAL_W-1:0]         csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // segment_kind, segment_length, start_level, end_level,
   // first_control_level, second_control_level, first_control_position,
   // second_control_position, zero fill
   input  logic [bss_pkg::IN_DATA_W-1:0]      req_tdata,
   input  logic                               req_tuser,   // action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bss_pkg::LVL_W-1:0]          rsp_tdata,   // sample_level
   output logic                               rsp_tlast,
   output logic                               rsp_tuser    // segment_empty
);

   bss_pkg::bss_cmd_type    cmd;
   bss_pkg::bss_status_type status;

   bss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bss_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .in_data    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_level  (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_empty  (rsp_tuser)
   );

endmodule
